// ===== src/icpe_pkg.sv =====
// Shared types and constants for the Ising chain phase evaluator.
// Holds the microcode ROM, the control word layouts and the fixed-point constants.
// No dependencies.
package icpe_pkg;

   // Energy accumulator width: covers 32 sites of full-scale field plus 31 bond terms.
   localparam int ACC_W = 22;
   localparam int E_W   = 21;
   localparam int STEP_W = 5;

   localparam logic signed [ACC_W-1:0] ACC_E_MAX = ACC_W'(1048575);
   localparam logic signed [ACC_W-1:0] ACC_E_MIN = -ACC_W'(1048576);
   localparam logic signed [ACC_W-1:0] ONE_Q12   = ACC_W'(4096);

   // round(2^32 / (2*pi)) and the Q30 sine polynomial coefficients
   localparam logic [31:0] INV_TWO_PI_Q32 = 32'd683565276;
   localparam logic [31:0] C1 = 32'd1686629713;
   localparam logic [31:0] C3 = 32'd693598668;
   localparam logic [31:0] C5 = 32'd85615197;
   localparam logic [31:0] C7 = 32'd5029692;
   localparam logic [31:0] C9 = 32'd172367;

   localparam logic [15:0] QUARTER_TURN = 16'd16384;
   localparam logic [14:0] ONE_Q14      = 15'd16384;

   // Request opcodes
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_EVAL = 1'b1;

   // Multiplier operations; the writeback of each follows in the cycle after it is issued
   localparam logic [2:0] MOP_NOP = 3'd0;
   localparam logic [2:0] MOP_ANG = 3'd1;
   localparam logic [2:0] MOP_U2  = 3'd2;
   localparam logic [2:0] MOP_T9  = 3'd3;
   localparam logic [2:0] MOP_T7  = 3'd4;
   localparam logic [2:0] MOP_T5  = 3'd5;
   localparam logic [2:0] MOP_T3  = 3'd6;
   localparam logic [2:0] MOP_S   = 3'd7;

   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(17);

   typedef struct packed {
      logic       site_en;
      logic       loop;
      logic       sat_en;
      logic [2:0] mul_op;
      logic       lane;
      logic       done;
   } icpe_uword_type;

   typedef struct packed {
      logic       start;
      logic       site_en;
      logic       sat_en;
      logic [2:0] mul_op;
      logic       lane;
      logic       done;
   } icpe_ctrl_type;

   typedef struct packed {
      logic site_last;
   } icpe_status_type;

   // Lane 0 computes the cosine, lane 1 the negated sine; lanes alternate on the multiplier.
   function automatic icpe_uword_type icpe_ucode(input logic [STEP_W-1:0] step);
      icpe_uword_type w;
      w = '0;
      w.mul_op = MOP_NOP;
      unique case (step)
         STEP_W'(0): begin
            w.site_en = 1'b1;
            w.loop    = 1'b1;
         end
         STEP_W'(1):  w.sat_en = 1'b1;
         STEP_W'(2):  w.mul_op = MOP_ANG;
         STEP_W'(4):  w.mul_op = MOP_U2;
         STEP_W'(5): begin
            w.mul_op = MOP_U2;
            w.lane   = 1'b1;
         end
         STEP_W'(6):  w.mul_op = MOP_T9;
         STEP_W'(7): begin
            w.mul_op = MOP_T9;
            w.lane   = 1'b1;
         end
         STEP_W'(8):  w.mul_op = MOP_T7;
         STEP_W'(9): begin
            w.mul_op = MOP_T7;
            w.lane   = 1'b1;
         end
         STEP_W'(10): w.mul_op = MOP_T5;
         STEP_W'(11): begin
            w.mul_op = MOP_T5;
            w.lane   = 1'b1;
         end
         STEP_W'(12): w.mul_op = MOP_T3;
         STEP_W'(13): begin
            w.mul_op = MOP_T3;
            w.lane   = 1'b1;
         end
         STEP_W'(14): w.mul_op = MOP_S;
         STEP_W'(15): begin
            w.mul_op = MOP_S;
            w.lane   = 1'b1;
         end
         LAST_STEP:   w.done = 1'b1;
         default:     w.mul_op = MOP_NOP;
      endcase
      return w;
   endfunction

endpackage

// ===== src/icpe_useq.sv =====
// Microcode sequencer: step counter, control ROM lookup and the site-loop jump.
// Depends on icpe_pkg.
module icpe_useq (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic                     out_free,
   input  icpe_pkg::icpe_status_type status,
   output icpe_pkg::icpe_ctrl_type   ctrl,
   output logic                     busy
);

   logic                            busy_ff, busy_in;
   logic [icpe_pkg::STEP_W-1:0]     step_ff, step_in;
   icpe_pkg::icpe_uword_type        uw;

   assign uw = icpe_pkg::icpe_ucode(step_ff);

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      if (!busy_ff) begin
         if (start) begin
            busy_in = 1'b1;
            step_in = '0;
         end
      end else if (uw.loop && !status.site_last) begin
         step_in = step_ff;
      end else if (uw.done) begin
         // hold on the last step until the result register frees up
         if (out_free) begin
            busy_in = 1'b0;
            step_in = '0;
         end
      end else begin
         step_in = step_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   always_comb begin
      ctrl.start   = start && !busy_ff;
      ctrl.site_en = busy_ff && uw.site_en;
      ctrl.sat_en  = busy_ff && uw.sat_en;
      ctrl.mul_op  = busy_ff ? uw.mul_op : icpe_pkg::MOP_NOP;
      ctrl.lane    = uw.lane;
      ctrl.done    = busy_ff && uw.done && out_free;
   end

   assign busy = busy_ff;

   ast_step_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> step_ff <= icpe_pkg::LAST_STEP)
      else $error("sequencer step beyond program");
   ast_loop_hold: assert property (@(posedge clock) disable iff (reset)
      busy_ff && step_ff == '0 && !status.site_last |=> busy_ff && step_ff == '0)
      else $error("site loop left early");
   ast_done_ends: assert property (@(posedge clock) disable iff (reset)
      ctrl.done |=> !busy_ff)
      else $error("sequencer still busy after done");

endmodule

// ===== src/icpe_dp.sv =====
// Datapath: field table, energy accumulator, shared 33x33 multiplier and two phase lanes.
// Driven by the control word from icpe_useq; depends on icpe_pkg.
module icpe_dp #(
   parameter int SITES = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  icpe_pkg::icpe_ctrl_type   ctrl,
   input  logic                      ld_en,
   input  logic [3:0]                ld_site,
   input  logic signed [15:0]        ld_value,
   input  logic [15:0]               basis,
   output icpe_pkg::icpe_status_type status,
   output logic signed [icpe_pkg::E_W-1:0] energy,
   output logic signed [15:0]        phase_real,
   output logic signed [15:0]        phase_imag
);

   localparam int TBL_DEPTH = (SITES < 16) ? SITES : 16;
   localparam int IDX_W     = $clog2(TBL_DEPTH);
   localparam int SITE_W    = $clog2(SITES);
   localparam int ACC_W     = icpe_pkg::ACC_W;

   logic signed [15:0]        tbl_ff [TBL_DEPTH];
   logic [TBL_DEPTH-1:0]      basis_ff;
   logic [SITES-1:0]          spin_vec;
   logic [SITE_W-1:0]         site_ff;
   logic                      prev_ff;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic signed [icpe_pkg::E_W-1:0] energy_ff, energy_in;

   logic signed [15:0]        h;
   logic                      spin;
   logic signed [ACC_W-1:0]   hx, bond;

   logic signed [32:0]        mul_a, mul_b;
   logic signed [65:0]        prod_in, prod_ff;
   logic [2:0]                wb_op_ff;
   logic                      wb_lane_ff;

   logic [30:0]               u_ff   [2];
   logic [30:0]               u2_ff  [2];
   logic [31:0]               t_ff   [2];
   logic                      flip_ff[2];
   logic signed [15:0]        res_ff [2];

   logic [15:0]               lane_ang[2];
   logic [30:0]               u_set   [2];
   logic                      flip_set[2];
   logic [31:0]               prod_q30;
   logic [31:0]               rnd;
   logic [14:0]               mag;
   logic signed [15:0]        res_in;
   logic [31:0]               t_in;

   // spins beyond the 16 basis bits are always down
   for (genvar k = 0; k < SITES; k++) begin : g_spin
      if (k < TBL_DEPTH) begin : g_bit
         assign spin_vec[k] = basis_ff[k];
      end else begin : g_zero
         assign spin_vec[k] = 1'b0;
      end
   end

   // ---------------- site pass ----------------
   always_comb begin
      spin = spin_vec[site_ff];
      h    = (32'(site_ff) < TBL_DEPTH) ? tbl_ff[site_ff[IDX_W-1:0]] : 16'sd0;
      hx   = ACC_W'(h);
      if (site_ff == '0) begin
         bond = '0;
      end else if (spin == prev_ff) begin
         bond = icpe_pkg::ONE_Q12;
      end else begin
         bond = -icpe_pkg::ONE_Q12;
      end
      acc_in = acc_ff + (spin ? hx : -hx) + bond;
      if (acc_ff > icpe_pkg::ACC_E_MAX) begin
         energy_in = icpe_pkg::E_W'(icpe_pkg::ACC_E_MAX);
      end else if (acc_ff < icpe_pkg::ACC_E_MIN) begin
         energy_in = icpe_pkg::E_W'(icpe_pkg::ACC_E_MIN);
      end else begin
         energy_in = acc_ff[icpe_pkg::E_W-1:0];
      end
   end

   assign status.site_last = (site_ff == SITE_W'(SITES - 1));

   // ---------------- shared multiplier ----------------
   always_comb begin
      unique case (ctrl.mul_op)
         icpe_pkg::MOP_NOP: begin
            mul_a = '0;
            mul_b = '0;
         end
         icpe_pkg::MOP_ANG: begin
            mul_a = 33'(energy_ff);
            mul_b = {1'b0, icpe_pkg::INV_TWO_PI_Q32};
         end
         icpe_pkg::MOP_U2: begin
            mul_a = {2'b00, u_ff[ctrl.lane]};
            mul_b = {2'b00, u_ff[ctrl.lane]};
         end
         icpe_pkg::MOP_T9: begin
            mul_a = {2'b00, u2_ff[ctrl.lane]};
            mul_b = {1'b0, icpe_pkg::C9};
         end
         icpe_pkg::MOP_T7, icpe_pkg::MOP_T5, icpe_pkg::MOP_T3: begin
            mul_a = {2'b00, u2_ff[ctrl.lane]};
            mul_b = {1'b0, t_ff[ctrl.lane]};
         end
         icpe_pkg::MOP_S: begin
            mul_a = {2'b00, u_ff[ctrl.lane]};
            mul_b = {1'b0, t_ff[ctrl.lane]};
         end
      endcase
      prod_in = mul_a * mul_b;
   end

   // ---------------- writeback ----------------
   always_comb begin
      logic [1:0]  q;
      logic [14:0] p;
      logic [14:0] pp;
      lane_ang[0] = prod_ff[43:28] + icpe_pkg::QUARTER_TURN;
      lane_ang[1] = prod_ff[43:28];
      for (int l = 0; l < 2; l++) begin
         q  = lane_ang[l][15:14];
         p  = {1'b0, lane_ang[l][13:0]};
         pp = q[0] ? (icpe_pkg::ONE_Q14 - p) : p;
         u_set[l]    = {pp, 16'h0000};
         // lane 1 carries minus sine, so its sign sense is inverted
         flip_set[l] = (l == 0) ? q[1] : !q[1];
      end
      prod_q30 = prod_ff[61:30];
      rnd      = prod_q30 + 32'd32768;
      mag      = (rnd[31:16] > 16'(icpe_pkg::ONE_Q14)) ? icpe_pkg::ONE_Q14 : rnd[30:16];
      res_in   = flip_ff[wb_lane_ff] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
      unique case (wb_op_ff)
         icpe_pkg::MOP_T9: t_in = icpe_pkg::C7 - prod_q30;
         icpe_pkg::MOP_T7: t_in = icpe_pkg::C5 - prod_q30;
         icpe_pkg::MOP_T5: t_in = icpe_pkg::C3 - prod_q30;
         icpe_pkg::MOP_T3: t_in = icpe_pkg::C1 - prod_q30;
         icpe_pkg::MOP_NOP, icpe_pkg::MOP_ANG, icpe_pkg::MOP_U2, icpe_pkg::MOP_S:
            t_in = t_ff[wb_lane_ff];
      endcase
   end

   // ---------------- control registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TBL_DEPTH; i++) begin
            tbl_ff[i] <= '0;
         end
         wb_op_ff   <= icpe_pkg::MOP_NOP;
         wb_lane_ff <= 1'b0;
         site_ff    <= '0;
      end else begin
         if (ld_en && 32'(ld_site) < SITES) begin
            tbl_ff[ld_site[IDX_W-1:0]] <= ld_value;
         end
         wb_op_ff   <= ctrl.mul_op;
         wb_lane_ff <= ctrl.lane;
         if (ctrl.start) begin
            site_ff <= '0;
         end else if (ctrl.site_en) begin
            site_ff <= site_ff + 1'b1;
         end
      end
   end

   // ---------------- payload registers ----------------
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (ctrl.start) begin
         basis_ff <= basis[TBL_DEPTH-1:0];
         acc_ff   <= '0;
      end else if (ctrl.site_en) begin
         acc_ff  <= acc_in;
         prev_ff <= spin;
      end
      if (ctrl.sat_en) begin
         energy_ff <= energy_in;
      end
      unique case (wb_op_ff)
         icpe_pkg::MOP_ANG: begin
            for (int l = 0; l < 2; l++) begin
               u_ff[l]    <= u_set[l];
               flip_ff[l] <= flip_set[l];
            end
         end
         icpe_pkg::MOP_U2: u2_ff[wb_lane_ff] <= prod_ff[60:30];
         icpe_pkg::MOP_T9, icpe_pkg::MOP_T7, icpe_pkg::MOP_T5, icpe_pkg::MOP_T3:
            t_ff[wb_lane_ff] <= t_in;
         icpe_pkg::MOP_S: res_ff[wb_lane_ff] <= res_in;
         icpe_pkg::MOP_NOP: begin
         end
      endcase
   end

   assign energy     = energy_ff;
   assign phase_real = res_ff[0];
   assign phase_imag = res_ff[1];

endmodule

// ===== src/ising_chain_phase_eval.sv =====
// Evaluate item: the microcode walks one site per cycle, then saturate, the multiplier
// steps of both phase lanes, a writeback and done.
// No new item is accepted until an evaluate item is done; a load item gives no result.
// A finished result waits in the output register while the next item is accepted.
// Reset (synchronous) clears the field table, the sequencer and the output valid.
// Top level; depends on icpe_pkg, icpe_useq and icpe_dp.
module ising_chain_phase_eval #(
   parameter int SITES = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_op,
   input  logic [3:0]          req_site,
   input  logic signed [15:0]  req_field_value,
   input  logic [15:0]         req_basis_state,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [20:0]  rsp_energy,
   output logic signed [15:0]  rsp_phase_real,
   output logic signed [15:0]  rsp_phase_imag
);

   icpe_pkg::icpe_ctrl_type   ctrl;
   icpe_pkg::icpe_status_type status;
   logic                      busy;
   logic                      out_free;
   logic                      req_fire;

   logic signed [20:0]        dp_energy;
   logic signed [15:0]        dp_real, dp_imag;

   logic                      rsp_valid_ff;
   logic signed [20:0]        rsp_energy_ff;
   logic signed [15:0]        rsp_real_ff, rsp_imag_ff;

   assign req_ready = !busy;
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   icpe_useq u_useq (
      .clock    (clock),
      .reset    (reset),
      .start    (req_fire && req_op == icpe_pkg::OP_EVAL),
      .out_free (out_free),
      .status   (status),
      .ctrl     (ctrl),
      .busy     (busy)
   );

   icpe_dp #(
      .SITES (SITES)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .ld_en      (req_fire && req_op == icpe_pkg::OP_LOAD),
      .ld_site    (req_site),
      .ld_value   (req_field_value),
      .basis      (req_basis_state),
      .status     (status),
      .energy     (dp_energy),
      .phase_real (dp_real),
      .phase_imag (dp_imag)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.done) begin
         rsp_energy_ff <= dp_energy;
         rsp_real_ff   <= dp_real;
         rsp_imag_ff   <= dp_imag;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_energy     = rsp_energy_ff;
   assign rsp_phase_real = rsp_real_ff;
   assign rsp_phase_imag = rsp_imag_ff;

   ast_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctrl.done |-> out_free)
      else $error("result register overwritten while waiting");
   ast_eval_blocks: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_op == icpe_pkg::OP_EVAL |=> !req_ready)
      else $error("evaluate item did not start the sequencer");
   ast_real_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_real_ff <= 16'sd16384 && rsp_real_ff >= -16'sd16384)
      else $error("cosine out of range");
   ast_imag_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_imag_ff <= 16'sd16384 && rsp_imag_ff >= -16'sd16384)
      else $error("sine out of range");

endmodule
